// File: rtl/binary_lifting_lca_macros.svh
// ----------------------------------------------------------------------------
// Binary lifting LCA assertion macros
// Concurrent assertion wrappers shared by the RTL files; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef BINARY_LIFTING_LCA_MACROS_SVH
`define BINARY_LIFTING_LCA_MACROS_SVH
`ifndef SYNTHESIS
`define BLCA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BLCA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BLCA_ASSERT_IMP(lbl, ante, cons, msg)
`define BLCA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/blca_pkg.sv
// ----------------------------------------------------------------------------
// Binary lifting LCA package
// Shared constants, controller states and the table write-enable group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blca_pkg;

    localparam int NODES_DEF  = 1024;
    localparam int LEVELS_DEF = 10;
    localparam int NODE_W     = 10;
    localparam int CMP_W      = 17;

    typedef logic [NODE_W-1:0] node_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_DEPTH,
        ST_LD_READ,
        ST_LD_WRITE,
        ST_Q_DEPTH,
        ST_Q_LIFT,
        ST_Q_LIFT_WAIT,
        ST_Q_CHECK,
        ST_Q_DESC,
        ST_Q_DESC_WAIT,
        ST_Q_LAST,
        ST_Q_LAST_WAIT,
        ST_DONE
    } blca_state_t;

    typedef struct packed {
        logic jump_we;
        logic depth_we;
    } blca_wr_t;

    function automatic int lvl_width(input int levels);
        return (levels > 1) ? $clog2(levels) : 1;
    endfunction

endpackage

// File: rtl/binary_lifting_lca.sv
// ----------------------------------------------------------------------------
// Binary lifting LCA engine
// Keeps a power-of-two ancestor table and a depth table for a preorder-loaded
// tree and answers lowest common ancestor queries.
// ----------------------------------------------------------------------------
// Usage: a transaction is taken when start is high while busy is low. With
// action low it loads node_a under parent_node; with action high it queries
// the lowest common ancestor of node_a and node_b. Each transaction gives one
// result: done is high for exactly one cycle with common_ancestor and
// load_done valid, and the receiver must take it then; it cannot stall.
// A load writes the depth entry and the level-0 jump entry, then fills the
// jump memory level by level, where each level reads the entry written for
// the level below it. A query reads both depths and lifts the deeper node by
// the depth difference one bit at a time, reading the jump memory for each
// set bit; if the nodes then differ, it descends from the top level to level
// zero, each step comparing the registered data of two jump memory reads,
// and a last read gives the parent. Rejected items (sentinel or out-of-range
// nodes) go from acceptance straight to done. A new transaction is taken
// only back in idle. After reset both tables are zeroed by a clearing pass,
// during which busy stays high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_lifting_lca_macros.svh"

module binary_lifting_lca #(
    parameter int NODES  = blca_pkg::NODES_DEF,
    parameter int LEVELS = blca_pkg::LEVELS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        action,
    input  logic [blca_pkg::NODE_W-1:0] node_a,
    input  logic [blca_pkg::NODE_W-1:0] node_b,
    input  logic [blca_pkg::NODE_W-1:0] parent_node,
    output logic                        done,
    output logic [blca_pkg::NODE_W-1:0] common_ancestor,
    output logic                        load_done
);

    localparam int NODE_AW = $clog2(NODES);
    localparam int LW      = blca_pkg::lvl_width(LEVELS);
    localparam int JAW     = NODE_AW + LW;
    localparam logic [LW-1:0] LAST_LVL = LW'(LEVELS - 1);
    localparam logic [LW-1:0] PREV_LVL = LW'(LEVELS - 2);
    localparam logic [blca_pkg::CMP_W-1:0] NODES_LIM = blca_pkg::CMP_W'(NODES);

    blca_pkg::blca_state_t state_reg;
    blca_pkg::blca_state_t state_next;

    blca_pkg::node_t   u_reg;
    blca_pkg::node_t   u_next;
    blca_pkg::node_t   v_reg;
    blca_pkg::node_t   v_next;
    logic [LEVELS-1:0] diff_reg;
    logic [LEVELS-1:0] diff_next;
    logic [LW-1:0]     level_reg;
    logic [LW-1:0]     level_next;
    blca_pkg::node_t   res_node_reg;
    blca_pkg::node_t   res_node_next;
    logic              res_load_reg;
    logic              res_load_next;

    blca_pkg::blca_wr_t wr;
    logic [JAW-1:0]     jump_waddr;
    blca_pkg::node_t    jump_wdata;
    logic [NODE_AW-1:0] depth_waddr;
    blca_pkg::node_t    depth_wdata;
    logic [JAW-1:0]     jump_raddr0;
    logic [JAW-1:0]     jump_raddr1;
    blca_pkg::node_t    jump_rdata0;
    blca_pkg::node_t    jump_rdata1;
    logic [NODE_AW-1:0] depth_raddr0;
    logic [NODE_AW-1:0] depth_raddr1;
    blca_pkg::node_t    depth_rdata0;
    blca_pkg::node_t    depth_rdata1;
    logic               clear_done;

    logic               accept;
    logic               load_ok;
    logic               query_ok;
    logic               swap;
    blca_pkg::node_t    diff_full;
    logic [NODE_AW-1:0] u_idx;
    logic [NODE_AW-1:0] v_idx;

    blca_tables #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_tables (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (wr),
        .jump_waddr   (jump_waddr),
        .jump_wdata   (jump_wdata),
        .depth_waddr  (depth_waddr),
        .depth_wdata  (depth_wdata),
        .jump_raddr0  (jump_raddr0),
        .jump_raddr1  (jump_raddr1),
        .jump_rdata0  (jump_rdata0),
        .jump_rdata1  (jump_rdata1),
        .depth_raddr0 (depth_raddr0),
        .depth_raddr1 (depth_raddr1),
        .depth_rdata0 (depth_rdata0),
        .depth_rdata1 (depth_rdata1),
        .clear_done   (clear_done)
    );

    assign busy   = (state_reg != blca_pkg::ST_IDLE);
    assign accept = start && !busy;

    assign load_ok  = (node_a != '0)
                   && (blca_pkg::CMP_W'(node_a) < NODES_LIM)
                   && (blca_pkg::CMP_W'(parent_node) < NODES_LIM);
    assign query_ok = (blca_pkg::CMP_W'(node_a) < NODES_LIM)
                   && (blca_pkg::CMP_W'(node_b) < NODES_LIM);

    assign swap      = (depth_rdata0 < depth_rdata1);
    assign diff_full = swap ? (depth_rdata1 - depth_rdata0) : (depth_rdata0 - depth_rdata1);

    assign u_idx = NODE_AW'(u_reg);
    assign v_idx = NODE_AW'(v_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            blca_pkg::ST_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = blca_pkg::ST_IDLE;
                end
            end
            blca_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (!action)
                    begin
                        state_next = load_ok ? blca_pkg::ST_LD_DEPTH : blca_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = query_ok ? blca_pkg::ST_Q_DEPTH : blca_pkg::ST_DONE;
                    end
                end
            end
            blca_pkg::ST_LD_DEPTH:
            begin
                state_next = (LEVELS == 1) ? blca_pkg::ST_DONE : blca_pkg::ST_LD_READ;
            end
            blca_pkg::ST_LD_READ:
            begin
                state_next = blca_pkg::ST_LD_WRITE;
            end
            blca_pkg::ST_LD_WRITE:
            begin
                state_next = (level_reg == PREV_LVL) ? blca_pkg::ST_DONE
                                                     : blca_pkg::ST_LD_READ;
            end
            blca_pkg::ST_Q_DEPTH:
            begin
                state_next = blca_pkg::ST_Q_LIFT;
            end
            blca_pkg::ST_Q_LIFT:
            begin
                if (diff_reg == '0)
                begin
                    state_next = blca_pkg::ST_Q_CHECK;
                end
                else if (diff_reg[0])
                begin
                    state_next = blca_pkg::ST_Q_LIFT_WAIT;
                end
            end
            blca_pkg::ST_Q_LIFT_WAIT:
            begin
                state_next = blca_pkg::ST_Q_LIFT;
            end
            blca_pkg::ST_Q_CHECK:
            begin
                state_next = (u_reg == v_reg) ? blca_pkg::ST_DONE : blca_pkg::ST_Q_DESC;
            end
            blca_pkg::ST_Q_DESC:
            begin
                state_next = blca_pkg::ST_Q_DESC_WAIT;
            end
            blca_pkg::ST_Q_DESC_WAIT:
            begin
                state_next = (level_reg == '0) ? blca_pkg::ST_Q_LAST : blca_pkg::ST_Q_DESC;
            end
            blca_pkg::ST_Q_LAST:
            begin
                state_next = blca_pkg::ST_Q_LAST_WAIT;
            end
            blca_pkg::ST_Q_LAST_WAIT:
            begin
                state_next = blca_pkg::ST_DONE;
            end
            blca_pkg::ST_DONE:
            begin
                state_next = blca_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = blca_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        u_next        = u_reg;
        v_next        = v_reg;
        diff_next     = diff_reg;
        level_next    = level_reg;
        res_node_next = res_node_reg;
        res_load_next = res_load_reg;
        wr            = '0;
        jump_waddr    = {v_idx, LW'(level_reg + 1'b1)};
        jump_wdata    = jump_rdata0;
        depth_waddr   = v_idx;
        depth_wdata   = depth_rdata0 + 1'b1;
        jump_raddr0   = {u_idx, level_reg};
        jump_raddr1   = {v_idx, level_reg};
        depth_raddr0  = NODE_AW'(node_a);
        depth_raddr1  = NODE_AW'(node_b);
        case (state_reg)
            blca_pkg::ST_IDLE:
            begin
                res_node_next = '0;
                res_load_next = 1'b0;
                if (!action)
                begin
                    depth_raddr0 = NODE_AW'(parent_node);
                    u_next       = parent_node;
                    v_next       = node_a;
                end
                else
                begin
                    u_next = node_a;
                    v_next = node_b;
                end
            end
            blca_pkg::ST_LD_DEPTH:
            begin
                wr.depth_we = 1'b1;
                wr.jump_we  = 1'b1;
                jump_waddr  = {v_idx, {LW{1'b0}}};
                jump_wdata  = u_reg;
                level_next  = '0;
                if (LEVELS == 1)
                begin
                    res_load_next = 1'b1;
                end
            end
            blca_pkg::ST_LD_WRITE:
            begin
                wr.jump_we = 1'b1;
                u_next     = jump_rdata0;
                level_next = LW'(level_reg + 1'b1);
                if (level_reg == PREV_LVL)
                begin
                    res_load_next = 1'b1;
                end
            end
            blca_pkg::ST_Q_DEPTH:
            begin
                if (swap)
                begin
                    u_next = v_reg;
                    v_next = u_reg;
                end
                diff_next  = LEVELS'(diff_full);
                level_next = '0;
            end
            blca_pkg::ST_Q_LIFT:
            begin
                if ((diff_reg != '0) && !diff_reg[0])
                begin
                    diff_next  = diff_reg >> 1;
                    level_next = LW'(level_reg + 1'b1);
                end
            end
            blca_pkg::ST_Q_LIFT_WAIT:
            begin
                u_next     = jump_rdata0;
                diff_next  = diff_reg >> 1;
                level_next = LW'(level_reg + 1'b1);
            end
            blca_pkg::ST_Q_CHECK:
            begin
                level_next    = LAST_LVL;
                res_node_next = u_reg;
            end
            blca_pkg::ST_Q_DESC_WAIT:
            begin
                if (jump_rdata0 != jump_rdata1)
                begin
                    u_next = jump_rdata0;
                    v_next = jump_rdata1;
                end
                if (level_reg != '0)
                begin
                    level_next = LW'(level_reg - 1'b1);
                end
            end
            blca_pkg::ST_Q_LAST_WAIT:
            begin
                res_node_next = jump_rdata0;
            end
            default:
            begin
                u_next = u_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blca_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg        <= u_next;
        v_reg        <= v_next;
        diff_reg     <= diff_next;
        level_reg    <= level_next;
        res_node_reg <= res_node_next;
        res_load_reg <= res_load_next;
    end

    assign done            = (state_reg == blca_pkg::ST_DONE);
    assign common_ancestor = res_node_reg;
    assign load_done       = res_load_reg;

    `BLCA_ASSERT_NXT(a_done_pulse, done, !done, "result strobe held for more than one cycle")
    `BLCA_ASSERT_IMP(a_clear_busy, !clear_done, busy, "transaction accepted during clearing pass")
    `BLCA_ASSERT_IMP(a_load_zero, done && load_done, common_ancestor == '0, "load result carries a nonzero ancestor")
    `BLCA_ASSERT_IMP(a_desc_level, state_reg == blca_pkg::ST_Q_DESC, level_reg <= LAST_LVL, "descent level out of range")
    `BLCA_ASSERT_NXT(a_accept_busy, accept, busy, "engine not busy after accepting a transaction")

endmodule

// File: rtl/blca_tables.sv
// ----------------------------------------------------------------------------
// Binary lifting LCA tables
// Jump and depth memories with one write and two registered read ports each,
// plus the clearing pass that zeroes both after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_lifting_lca_macros.svh"

module blca_tables #(
    parameter int NODES  = blca_pkg::NODES_DEF,
    parameter int LEVELS = blca_pkg::LEVELS_DEF,
    localparam int NODE_AW = $clog2(NODES),
    localparam int LW      = blca_pkg::lvl_width(LEVELS),
    localparam int JAW     = NODE_AW + LW
) (
    input  logic              clk,
    input  logic              rst_n,
    input  blca_pkg::blca_wr_t wr,
    input  logic [JAW-1:0]    jump_waddr,
    input  blca_pkg::node_t   jump_wdata,
    input  logic [NODE_AW-1:0] depth_waddr,
    input  blca_pkg::node_t   depth_wdata,
    input  logic [JAW-1:0]    jump_raddr0,
    input  logic [JAW-1:0]    jump_raddr1,
    output blca_pkg::node_t   jump_rdata0,
    output blca_pkg::node_t   jump_rdata1,
    input  logic [NODE_AW-1:0] depth_raddr0,
    input  logic [NODE_AW-1:0] depth_raddr1,
    output blca_pkg::node_t   depth_rdata0,
    output blca_pkg::node_t   depth_rdata1,
    output logic              clear_done
);

    localparam int JUMP_DEPTH  = 1 << JAW;
    localparam int DEPTH_DEPTH = 1 << NODE_AW;

    blca_pkg::node_t jump_mem  [JUMP_DEPTH];
    blca_pkg::node_t depth_mem [DEPTH_DEPTH];

    logic [JAW-1:0]     clr_cnt_reg;
    logic [JAW-1:0]     clr_cnt_next;
    logic               clr_done_reg;
    logic               clr_done_next;

    logic               jump_we;
    logic [JAW-1:0]     jump_addr;
    blca_pkg::node_t    jump_data;
    logic               depth_we;
    logic [NODE_AW-1:0] depth_addr;
    blca_pkg::node_t    depth_data;

    blca_pkg::node_t    jump_rd0_reg;
    blca_pkg::node_t    jump_rd1_reg;
    blca_pkg::node_t    depth_rd0_reg;
    blca_pkg::node_t    depth_rd1_reg;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_done_next = clr_done_reg;
        if (!clr_done_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (&clr_cnt_reg)
            begin
                clr_done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_done_reg <= clr_done_next;
        end
    end

    always_comb
    begin
        if (clr_done_reg)
        begin
            jump_we    = wr.jump_we;
            jump_addr  = jump_waddr;
            jump_data  = jump_wdata;
            depth_we   = wr.depth_we;
            depth_addr = depth_waddr;
            depth_data = depth_wdata;
        end
        else
        begin
            jump_we    = 1'b1;
            jump_addr  = clr_cnt_reg;
            jump_data  = '0;
            depth_we   = 1'b1;
            depth_addr = clr_cnt_reg[JAW-1:LW];
            depth_data = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (jump_we)
        begin
            jump_mem[jump_addr] <= jump_data;
        end
        jump_rd0_reg <= jump_mem[jump_raddr0];
        jump_rd1_reg <= jump_mem[jump_raddr1];
    end

    always_ff @(posedge clk)
    begin
        if (depth_we)
        begin
            depth_mem[depth_addr] <= depth_data;
        end
        depth_rd0_reg <= depth_mem[depth_raddr0];
        depth_rd1_reg <= depth_mem[depth_raddr1];
    end

    assign jump_rdata0  = jump_rd0_reg;
    assign jump_rdata1  = jump_rd1_reg;
    assign depth_rdata0 = depth_rd0_reg;
    assign depth_rdata1 = depth_rd1_reg;
    assign clear_done   = clr_done_reg;

    `BLCA_ASSERT_IMP(a_no_write_in_clear, !clr_done_reg, !(wr.jump_we || wr.depth_we), "table write requested during clearing pass")

endmodule
